>>> src/periodic_timer_table_event_queue_core_defines.svh
// ============================================================================
// Assertion macros for the periodic timer table core
// Shared property templates, clocked on i_clk and held off during reset.
// ============================================================================
`ifndef PERIODIC_TIMER_TABLE_EVENT_QUEUE_CORE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_EVENT_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTTEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTTEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ptteq_pkg.sv
// ============================================================================
// Periodic timer table package
// Field widths, command codes, word and slot types and controller states.
// ============================================================================
package ptteq_pkg;

    localparam int ID_BITS         = 8;
    localparam int PARAM_BITS      = 16;
    localparam int COUNT_BITS      = 16;
    localparam int CMD_BITS        = 3;
    localparam int TIMER_SLOTS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [CMD_BITS-1:0] CMD_SET   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_KILL  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_POST  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_FETCH = 3'd4;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [ID_BITS-1:0]    msg_id;
        logic [PARAM_BITS-1:0] msg_param;
        logic [COUNT_BITS-1:0] period;
    } t_in_word;

    typedef struct packed {
        logic                  msg_valid;
        logic [ID_BITS-1:0]    out_id;
        logic [PARAM_BITS-1:0] out_param;
    } t_out_word;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [PARAM_BITS-1:0] param;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] period;
    } t_slot;

    // Key compared in every cell, and also the shape of one queued event.
    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [PARAM_BITS-1:0] param;
    } t_event;

    typedef struct packed {
        logic free;
        logic id_eq;
        logic hit;
    } t_cell_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_POST,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

>>> src/ptteq_cell.sv
// ============================================================================
// Timer slot cell
// Holds one timer slot, passes it on when the ring rotates and compares the
// held slot against the broadcast key.
// ============================================================================
module ptteq_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  ptteq_pkg::t_slot       i_slot,
    input  ptteq_pkg::t_event      i_key,
    output ptteq_pkg::t_slot       o_slot,
    output ptteq_pkg::t_cell_flags o_flags
);

    ptteq_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    always_comb begin
        o_flags.free  = (r_slot.id == '0);
        o_flags.id_eq = (r_slot.id == i_key.id);
        o_flags.hit   = !o_flags.free && o_flags.id_eq && (r_slot.param == i_key.param);
    end

    assign o_slot = r_slot;

endmodule

>>> src/ptteq_queue.sv
// ============================================================================
// Event ring buffer
// Circular event store; a push onto a full ring drops the oldest word.
// ============================================================================
module ptteq_queue #(
    parameter int QUEUE_DEPTH = ptteq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptteq_pkg::t_event i_push_data,
    input  logic              i_pop,
    output logic              o_rd_valid,
    output ptteq_pkg::t_event o_rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    ptteq_pkg::t_event r_mem [QUEUE_DEPTH];
    ptteq_pkg::t_event r_rd_data;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic              r_rd_valid;
    logic [PTR_W-1:0]  w_head_nx;
    logic [PTR_W-1:0]  w_tail_nx;
    logic              w_nonempty;

    assign w_head_nx  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_tail_nx  = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign w_nonempty = (r_head != r_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_head <= w_head_nx;
                // Ring full: the tail steps forward, so the oldest word is dropped.
                if (w_head_nx == r_tail) begin
                    r_tail <= w_tail_nx;
                end
            end else if (i_pop) begin
                r_rd_valid <= w_nonempty;
                if (w_nonempty) begin
                    r_tail <= w_tail_nx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[w_head_nx] <= i_push_data;
        end
        if (i_pop && w_nonempty) begin
            r_rd_data <= r_mem[w_tail_nx];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_data  = r_rd_data;

endmodule

>>> src/periodic_timer_table_event_queue_core.sv
// ============================================================================
// Periodic timer table with event ring
// Timer slots circulate through a ring of cells past one update point; fired
// and posted events go into a ring buffer that fetch commands drain.
// ============================================================================
//  channel | direction | handshake              | word
//  in      | input     | i_in_valid / o_in_stall  | i_in_word  (cmd, id, param, period)
//  out     | output    | o_out_valid / i_out_stall | o_out_word (valid, id, param)
//
// Kill and tick take one rotation of the slot ring.
// Set takes one rotation when a slot matches or none is free, and a second
// rotation when a free slot is filled.
// Post pushes one event; fetch does one registered read of the event memory.
// Reset clears all slots and the ring pointers; the event memory is not cleared.
// A new word is taken while the previous result waits in the output register;
// the controller holds only when it finishes while that register is still full.
// ============================================================================
`include "periodic_timer_table_event_queue_core_defines.svh"

module periodic_timer_table_event_queue_core #(
    parameter int TIMER_SLOTS = ptteq_pkg::TIMER_SLOTS_DEF,
    parameter int QUEUE_DEPTH = ptteq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptteq_pkg::t_in_word i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptteq_pkg::t_out_word o_out_word
);

    localparam int POS_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    ptteq_pkg::t_state    r_state;
    ptteq_pkg::t_state    n_state;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [ptteq_pkg::CMD_BITS-1:0]   r_cmd;
    logic [ptteq_pkg::ID_BITS-1:0]    r_id;
    logic [ptteq_pkg::PARAM_BITS-1:0] r_param;
    logic [ptteq_pkg::COUNT_BITS-1:0] r_period;
    logic                 r_matched;
    logic                 n_matched;
    logic                 r_free_found;
    logic                 n_free_found;
    logic [POS_W-1:0]     r_free_idx;
    logic [POS_W-1:0]     n_free_idx;
    logic                 r_out_valid;
    ptteq_pkg::t_out_word r_out_word;

    ptteq_pkg::t_slot       w_cell_out   [TIMER_SLOTS];
    ptteq_pkg::t_cell_flags w_cell_flags [TIMER_SLOTS];
    ptteq_pkg::t_slot       w_proc;
    ptteq_pkg::t_event      w_key;
    ptteq_pkg::t_event      w_push_data;
    ptteq_pkg::t_event      w_rd_data;
    ptteq_pkg::t_out_word   w_result;
    logic                   w_rd_valid;
    logic                   w_accept;
    logic                   w_shift;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_load;
    logic                   w_last;
    logic                   w_out_free;
    logic                   w_scan_set;

    assign w_key      = '{id: r_id, param: r_param};
    assign w_accept   = i_in_valid && (r_state == ptteq_pkg::ST_IDLE);
    assign w_last     = (r_pos == POS_W'(TIMER_SLOTS - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_scan_set = (r_state == ptteq_pkg::ST_SCAN) && (r_cmd == ptteq_pkg::CMD_SET);

    // Slot ring: each cell takes its upper neighbor; the top cell takes the
    // slot that leaves cell 0 after the update point has worked on it.
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        if (i == TIMER_SLOTS - 1) begin : g_top
            ptteq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_proc),
                .i_key   (w_key),
                .o_slot  (w_cell_out[i]),
                .o_flags (w_cell_flags[i])
            );
        end else begin : g_mid
            ptteq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_cell_out[i+1]),
                .i_key   (w_key),
                .o_slot  (w_cell_out[i]),
                .o_flags (w_cell_flags[i])
            );
        end
    end

    ptteq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_rd_valid  (w_rd_valid),
        .o_rd_data   (w_rd_data)
    );

    // Set bookkeeping: slots pass in ascending order, so the last free one
    // seen is the highest-numbered one.
    always_comb begin
        n_matched    = r_matched;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        if (w_accept) begin
            n_matched    = 1'b0;
            n_free_found = 1'b0;
        end else if (w_scan_set) begin
            if (w_cell_flags[0].hit) begin
                n_matched = 1'b1;
            end
            if (w_cell_flags[0].free) begin
                n_free_found = 1'b1;
                n_free_idx   = r_pos;
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (w_shift) begin
            n_pos = w_last ? '0 : r_pos + POS_W'(1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptteq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.cmd)
                        ptteq_pkg::CMD_SET,
                        ptteq_pkg::CMD_KILL,
                        ptteq_pkg::CMD_TICK:  n_state = ptteq_pkg::ST_SCAN;
                        ptteq_pkg::CMD_POST:  n_state = ptteq_pkg::ST_POST;
                        ptteq_pkg::CMD_FETCH: n_state = ptteq_pkg::ST_READ;
                        default:              n_state = ptteq_pkg::ST_DONE;
                    endcase
                end
            end
            ptteq_pkg::ST_SCAN: begin
                if (w_last) begin
                    if ((r_cmd == ptteq_pkg::CMD_SET) && !n_matched && n_free_found) begin
                        n_state = ptteq_pkg::ST_FILL;
                    end else begin
                        n_state = ptteq_pkg::ST_DONE;
                    end
                end
            end
            ptteq_pkg::ST_FILL: begin
                if (w_last) begin
                    n_state = ptteq_pkg::ST_DONE;
                end
            end
            ptteq_pkg::ST_POST: n_state = ptteq_pkg::ST_DONE;
            ptteq_pkg::ST_READ: n_state = ptteq_pkg::ST_DONE;
            ptteq_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ptteq_pkg::ST_IDLE;
                end
            end
            default: n_state = ptteq_pkg::ST_IDLE;
        endcase
    end

    // Outputs: ring rotation, slot update at the loop point, queue access.
    always_comb begin
        w_shift     = 1'b0;
        w_proc      = w_cell_out[0];
        w_push      = 1'b0;
        w_push_data = w_key;
        w_pop       = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ptteq_pkg::ST_SCAN: begin
                w_shift = 1'b1;
                case (r_cmd)
                    ptteq_pkg::CMD_SET: begin
                        if (w_cell_flags[0].hit) begin
                            w_proc.count  = r_period;
                            w_proc.period = r_period;
                        end
                    end
                    ptteq_pkg::CMD_KILL: begin
                        if (w_cell_flags[0].id_eq) begin
                            w_proc.id = '0;
                        end
                    end
                    ptteq_pkg::CMD_TICK: begin
                        if (!w_cell_flags[0].free) begin
                            if (w_cell_out[0].count == '0) begin
                                w_proc.count = w_cell_out[0].period;
                                w_push       = 1'b1;
                                w_push_data  = '{id: w_cell_out[0].id,
                                                 param: w_cell_out[0].param};
                            end else begin
                                w_proc.count = w_cell_out[0].count -
                                               ptteq_pkg::COUNT_BITS'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ptteq_pkg::ST_FILL: begin
                w_shift = 1'b1;
                if (r_pos == r_free_idx) begin
                    w_proc = '{id: r_id, param: r_param, count: r_period, period: r_period};
                end
            end
            ptteq_pkg::ST_POST: w_push = 1'b1;
            ptteq_pkg::ST_READ: w_pop  = 1'b1;
            ptteq_pkg::ST_DONE: w_load = w_out_free;
            default: ;
        endcase
    end

    // A fetched id of zero is consumed but reported as no word.
    always_comb begin
        w_result = '0;
        if ((r_cmd == ptteq_pkg::CMD_FETCH) && w_rd_valid && (w_rd_data.id != '0)) begin
            w_result = '{msg_valid: 1'b1, out_id: w_rd_data.id, out_param: w_rd_data.param};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptteq_pkg::ST_IDLE;
            r_pos        <= '0;
            r_matched    <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_matched    <= n_matched;
            r_free_found <= n_free_found;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        if (w_accept) begin
            r_cmd    <= i_in_word.cmd;
            r_id     <= i_in_word.msg_id;
            r_param  <= i_in_word.msg_param;
            r_period <= i_in_word.period;
        end
        if (w_load) begin
            r_out_word <= w_result;
        end
    end

    assign o_in_stall  = (r_state != ptteq_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `PTTEQ_ASSERT_NOW(a_push_state, w_push,
        (r_state == ptteq_pkg::ST_SCAN) || (r_state == ptteq_pkg::ST_POST),
        "queue push outside scan or post")
    `PTTEQ_ASSERT_NOW(a_ring_home, r_state == ptteq_pkg::ST_IDLE, r_pos == '0,
        "slot ring not aligned when idle")
    `PTTEQ_ASSERT_NOW(a_fill_cause, r_state == ptteq_pkg::ST_FILL,
        r_free_found && !r_matched, "fill pass without a free slot or after a match")
    `PTTEQ_ASSERT_NEXT(a_fill_end, (r_state == ptteq_pkg::ST_FILL) && w_last,
        r_state == ptteq_pkg::ST_DONE, "fill pass did not end after one rotation")

endmodule

>>> dv/ptteq_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event checker for the periodic timer table core
// Watches both channels, keeps its own copy of the timer slots and the event
// ring, predicts the result word of every accepted command word and compares
// each returned word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ptteq_event_checker
    import ptteq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int TIMERS     = TIMER_SLOTS_DEF;
    localparam int RING_DEPTH = QUEUE_DEPTH_DEF;

    t_slot     timers [TIMERS];
    t_event    ring [RING_DEPTH];
    int        wr_ptr;
    int        rd_ptr;
    t_out_word due_words [$];
    int        mismatch_count;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // A full ring drops its oldest event: the write pointer lands on the read pointer.
    task automatic push_event(input t_event e);
        wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
        ring[wr_ptr] = e;
        if (wr_ptr == rd_ptr) begin
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        end
    endtask

    task automatic advance_table(input t_in_word w, output t_out_word r);
        int     free_idx;
        bit     hit;
        t_event e;
        r        = '0;
        free_idx = -1;
        hit      = 1'b0;
        case (w.cmd)
            CMD_SET: begin
                // The scan stops at the first matching slot, so free slots after it
                // never matter; without a match the highest free slot is filled.
                for (int i = 0; i < TIMERS; i++) begin
                    if (!hit) begin
                        if (timers[i].id == '0) begin
                            free_idx = i;
                        end else if (timers[i].id == w.msg_id &&
                                     timers[i].param == w.msg_param) begin
                            timers[i].count  = w.period;
                            timers[i].period = w.period;
                            hit              = 1'b1;
                        end
                    end
                end
                if (!hit && free_idx >= 0) begin
                    timers[free_idx].id     = w.msg_id;
                    timers[free_idx].param  = w.msg_param;
                    timers[free_idx].count  = w.period;
                    timers[free_idx].period = w.period;
                end
            end
            CMD_KILL: begin
                for (int i = 0; i < TIMERS; i++) begin
                    if (timers[i].id == w.msg_id) begin
                        timers[i].id = '0;
                    end
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < TIMERS; i++) begin
                    if (timers[i].id != '0) begin
                        if (timers[i].count == '0) begin
                            timers[i].count = timers[i].period;
                            e.id            = timers[i].id;
                            e.param         = timers[i].param;
                            push_event(e);
                        end else begin
                            timers[i].count = timers[i].count - 1'b1;
                        end
                    end
                end
            end
            CMD_POST: begin
                e.id    = w.msg_id;
                e.param = w.msg_param;
                push_event(e);
            end
            CMD_FETCH: begin
                if (wr_ptr != rd_ptr) begin
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    e      = ring[rd_ptr];
                    // An event with id zero is consumed but comes back as all zero.
                    if (e.id != '0) begin
                        r.msg_valid = 1'b1;
                        r.out_id    = e.id;
                        r.out_param = e.param;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_word;
        t_out_word new_word;
        if (!i_rst_n) begin
            for (int i = 0; i < TIMERS; i++) begin
                timers[i] = '0;
            end
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring[i] = '0;
            end
            wr_ptr = 0;
            rd_ptr = 0;
            due_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    report_mismatch($sformatf("result word %p with none expected",
                                              i_out_word));
                end else begin
                    exp_word = due_words.pop_front();
                    if (i_out_word.msg_valid !== exp_word.msg_valid) begin
                        report_mismatch($sformatf("msg_valid got %b expected %b",
                                                  i_out_word.msg_valid,
                                                  exp_word.msg_valid));
                    end
                    if (i_out_word.out_id !== exp_word.out_id) begin
                        report_mismatch($sformatf("out_id got 0x%h expected 0x%h",
                                                  i_out_word.out_id, exp_word.out_id));
                    end
                    if (i_out_word.out_param !== exp_word.out_param) begin
                        report_mismatch($sformatf("out_param got 0x%h expected 0x%h",
                                                  i_out_word.out_param,
                                                  exp_word.out_param));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_table(i_in_word, new_word);
                due_words.push_back(new_word);
            end
        end
        o_pending <= due_words.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the periodic timer table core
// Drives a directed run through the corner cases of the timer table and the
// event ring, then about 900 random command words in bursts, while the
// result side stalls on its own pattern. The event checker judges the words.
// ----------------------------------------------------------------------------
module tb;
    import ptteq_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_WORDS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT    = 400000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit random_phase = 1'b0;
    bit hold_done    = 1'b0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    periodic_timer_table_event_queue_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    ptteq_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in_word cmd_word(input logic [CMD_BITS-1:0] cmd,
                                          input logic [ID_BITS-1:0] id,
                                          input logic [PARAM_BITS-1:0] param,
                                          input logic [COUNT_BITS-1:0] period);
        t_in_word w;
        w.cmd       = cmd;
        w.msg_id    = id;
        w.msg_param = param;
        w.period    = period;
        return w;
    endfunction

    // Mostly a few small ids so that sets match and kills hit live slots.
    function automatic logic [ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return ID_BITS'($urandom);
        return ID_BITS'($urandom_range(1, 6));
    endfunction

    function automatic t_in_word random_command();
        t_in_word w;
        int       pick;
        int       r;
        w.msg_id    = ID_BITS'($urandom);
        w.msg_param = PARAM_BITS'($urandom);
        w.period    = COUNT_BITS'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 22) begin
            w.cmd    = CMD_SET;
            w.msg_id = pick_id();
            if ($urandom_range(0, 1) == 0) begin
                w.msg_param = PARAM_BITS'($urandom_range(0, 2));
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                w.period = COUNT_BITS'($urandom_range(0, 3));
            end else if (r < 9) begin
                w.period = COUNT_BITS'($urandom_range(4, 20));
            end
        end else if (pick < 32) begin
            w.cmd    = CMD_KILL;
            w.msg_id = pick_id();
        end else if (pick < 52) begin
            w.cmd = CMD_TICK;
        end else if (pick < 68) begin
            w.cmd    = CMD_POST;
            w.msg_id = pick_id();
        end else if (pick < 95) begin
            w.cmd = CMD_FETCH;
        end else begin
            w.cmd = CMD_BITS'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        return w;
    endfunction

    // Offers one word, waits for it to be taken, and ends the burst with a gap
    // when the burst has run out.
    task automatic offer_word(input t_in_word w);
        int gap;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 20);
            burst_left = $urandom_range(0, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: segments of differing stall density, and once a long hold
    // while random words keep coming, so that the block backs up to its input.
    initial begin
        int mode;
        int len;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (random_phase && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 80);
            repeat (len) begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fetch from the empty ring, then the unused command codes.
        offer_word(cmd_word(CMD_FETCH, '1, '1, '1));
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
            offer_word(cmd_word(CMD_BITS'(c), '1, '1, '1));
        end
        // A posted event with id zero is consumed but reported as no event.
        offer_word(cmd_word(CMD_POST, '0, '1, '0));
        offer_word(cmd_word(CMD_FETCH, '0, '0, '0));
        // A set with id zero writes a slot that stays free.
        offer_word(cmd_word(CMD_SET, '0, 16'h1234, 16'd3));
        offer_word(cmd_word(CMD_SET, '1, '1, '0));
        offer_word(cmd_word(CMD_SET, '1, '1, 16'd1));
        offer_word(cmd_word(CMD_SET, 8'd1, '0, '1));
        for (int id = 2; id <= 7; id++) begin
            offer_word(cmd_word(CMD_SET, ID_BITS'(id), PARAM_BITS'(id), '0));
        end
        // Every slot is taken now, so this set is dropped.
        offer_word(cmd_word(CMD_SET, 8'd9, 16'd9, '0));
        // Three ticks fire enough events to overrun the ring.
        repeat (3) offer_word(cmd_word(CMD_TICK, '0, '0, '0));
        offer_word(cmd_word(CMD_KILL, '0, '0, '0));
        offer_word(cmd_word(CMD_KILL, '1, '0, '0));
        repeat (2) offer_word(cmd_word(CMD_FETCH, '0, '0, '0));

        random_phase = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3) begin
                wait_all_results();
            end
            offer_word(random_command());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> periodic_timer_table_event_queue_core.f
+incdir+src
src/ptteq_pkg.sv
src/ptteq_cell.sv
src/ptteq_queue.sv
src/periodic_timer_table_event_queue_core.sv
dv/ptteq_event_checker.sv
dv/tb.sv
